FILE: hw/rtl/fir31_pkg.sv
// Shared types, constants and the coefficient table of the 31-tap FIR filter.
`timescale 1ns / 1ps

package fir31_pkg;

    // Coefficient format: signed Q1.15
    localparam int COEF_BITS  = 16;
    localparam int FRAC_SHIFT = COEF_BITS - 1;

    // Output word
    localparam int OUT_BITS = 16;
    localparam int OUT_MAX  = 32767;
    localparam int OUT_MIN  = -32768;

    // Coefficient table index covers the largest supported tap count (64)
    localparam int TAP_IDX_W = 6;
    localparam int MAX_TAPS  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } fsm_state_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic                 clear;      // zero the accumulator
        logic                 issue;      // a delay-line read is in flight this cycle
        logic [TAP_IDX_W-1:0] coef_idx;   // tap number of the issued read
        logic                 ent_valid;  // entry written since reset
        logic                 load;       // round and load the output register
    } mac_ctl_t;

    // Symmetric low-pass table; taps past the table are zero
    function automatic logic signed [COEF_BITS-1:0] coef_lookup(
        input logic [TAP_IDX_W-1:0] idx
    );
        logic signed [COEF_BITS-1:0] c;
        unique case (idx)
            6'd0, 6'd30:  c = -16'sd24;
            6'd1, 6'd29:  c = -16'sd12;
            6'd2, 6'd28:  c = 16'sd8;
            6'd3, 6'd27:  c = 16'sd50;
            6'd4, 6'd26:  c = 16'sd129;
            6'd5, 6'd25:  c = 16'sd256;
            6'd6, 6'd24:  c = 16'sd439;
            6'd7, 6'd23:  c = 16'sd682;
            6'd8, 6'd22:  c = 16'sd976;
            6'd9, 6'd21:  c = 16'sd1309;
            6'd10, 6'd20: c = 16'sd1659;
            6'd11, 6'd19: c = 16'sd1999;
            6'd12, 6'd18: c = 16'sd2302;
            6'd13, 6'd17: c = 16'sd2541;
            6'd14, 6'd16: c = 16'sd2694;
            6'd15:        c = 16'sd2747;
            default:      c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/fir31_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fir31_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 31
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fir31_mac.sv
// Shared multiply-accumulate unit with rounding, saturation and output register.
`timescale 1ns / 1ps

module fir31_mac #(
    parameter int TAPS        = 31,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fir31_pkg::mac_ctl_t                   ctl,
    input  logic [SAMPLE_BITS-1:0]                rd_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fir31_pkg::OUT_BITS-1:0] filtered
);

    localparam int PROD_W = SAMPLE_BITS + fir31_pkg::COEF_BITS;
    localparam int ACC_W  = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 1);
    localparam int RND_W  = ACC_W + 1;
    localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) << (fir31_pkg::FRAC_SHIFT - 1);
    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(fir31_pkg::OUT_MAX);
    localparam logic signed [RND_W-1:0] SAT_MIN = RND_W'(fir31_pkg::OUT_MIN);

    // stage 1: RAM data arrives
    logic                               s1_vld_reg;
    logic [fir31_pkg::TAP_IDX_W-1:0]    s1_idx_reg;
    logic                               s1_ent_reg;
    // stage 2: product
    logic                               s2_vld_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [PROD_W-1:0]           prod_next;
    logic signed [SAMPLE_BITS-1:0]      x_s1;
    logic signed [fir31_pkg::COEF_BITS-1:0] coef_s1;
    // accumulator and output
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [RND_W-1:0]            acc_ext;
    logic signed [RND_W-1:0]            rnd_sum;
    logic signed [RND_W-1:0]            rnd_shift;
    logic signed [fir31_pkg::OUT_BITS-1:0] filtered_next;
    logic signed [fir31_pkg::OUT_BITS-1:0] filtered_reg;
    logic                               out_valid_reg;

    // never-written entries read as zero history
    assign x_s1      = s1_ent_reg ? $signed(rd_data) : '0;
    assign coef_s1   = fir31_pkg::coef_lookup(s1_idx_reg);
    assign prod_next = x_s1 * coef_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctl.issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= ctl.coef_idx;
        s1_ent_reg <= ctl.ent_valid;
        prod_reg   <= prod_next;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, then floor shift
    assign acc_ext   = RND_W'(acc_reg);
    assign rnd_sum   = acc_ext + HALF;
    assign rnd_shift = rnd_sum >>> fir31_pkg::FRAC_SHIFT;

    always_comb
    begin
        priority if (rnd_shift > SAT_MAX)
        begin
            filtered_next = SAT_MAX[fir31_pkg::OUT_BITS-1:0];
        end
        else if (rnd_shift < SAT_MIN)
        begin
            filtered_next = SAT_MIN[fir31_pkg::OUT_BITS-1:0];
        end
        else
        begin
            filtered_next = rnd_shift[fir31_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // accumulator must be empty of in-flight products when cleared or read out
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !s1_vld_reg && !s2_vld_reg)
        else $error("accumulator cleared with products in flight");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !s1_vld_reg && !s2_vld_reg && !ctl.issue)
        else $error("output loaded before pipeline drained");

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");

endmodule

FILE: hw/rtl/fir31_ctrl.sv
// Sequencer: delay-line write pointer, tap walk and valid bits.
`timescale 1ns / 1ps

module fir31_ctrl #(
    parameter int TAPS        = 31,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [SAMPLE_BITS-1:0]                sample,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  ram_we,
    output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] ram_waddr,
    output logic [SAMPLE_BITS-1:0]                ram_wdata,
    output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] ram_raddr,
    output fir31_pkg::mac_ctl_t                   ctl
);

    localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(TAPS - 1);

    fir31_pkg::fsm_state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] tap_reg, tap_next;
    logic [TAPS-1:0]  valid_reg, valid_next;
    logic             accept;
    logic             last_tap;
    logic             load_ok;

    assign accept   = in_valid && in_ready;
    assign last_tap = (tap_reg == LAST);
    assign load_ok  = !out_valid || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fir31_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fir31_pkg::ST_RUN;
                end
            end
            fir31_pkg::ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = fir31_pkg::ST_DRAIN1;
                end
            end
            fir31_pkg::ST_DRAIN1: state_next = fir31_pkg::ST_DRAIN2;
            fir31_pkg::ST_DRAIN2: state_next = fir31_pkg::ST_FINISH;
            fir31_pkg::ST_FINISH:
            begin
                if (load_ok)
                begin
                    state_next = fir31_pkg::ST_IDLE;
                end
            end
            default: state_next = fir31_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctl.clear     = 1'b0;
        ctl.issue     = 1'b0;
        ctl.load      = 1'b0;
        ctl.coef_idx  = fir31_pkg::TAP_IDX_W'(tap_reg);
        ctl.ent_valid = valid_reg[idx_reg];
        unique case (state_reg)
            fir31_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctl.clear = in_valid;
            end
            fir31_pkg::ST_RUN:    ctl.issue = 1'b1;
            fir31_pkg::ST_DRAIN1: ;
            fir31_pkg::ST_DRAIN2: ;
            fir31_pkg::ST_FINISH: ctl.load = load_ok;
            default: ;
        endcase
    end

    assign ram_we        = accept;
    assign ram_waddr     = wp_reg;
    assign ram_wdata     = sample;
    assign ram_raddr     = idx_reg;

    // pointers: walk from the newest entry backward, wrapping at the top
    always_comb
    begin
        wp_next    = wp_reg;
        idx_next   = idx_reg;
        tap_next   = tap_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next[wp_reg] = 1'b1;
            idx_next           = wp_reg;
            tap_next           = '0;
            wp_next            = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
        end
        else if (state_reg == fir31_pkg::ST_RUN && !last_tap)
        begin
            tap_next = tap_reg + 1'b1;
            idx_next = (idx_reg == '0) ? LAST : idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fir31_pkg::ST_IDLE;
            wp_reg    <= '0;
            idx_reg   <= '0;
            tap_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            idx_reg   <= idx_next;
            tap_reg   <= tap_next;
            valid_reg <= valid_next;
        end
    end

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST && idx_reg <= LAST)
        else $error("delay-line pointer out of range");

    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg[$past(wp_reg)])
        else $error("written entry not marked valid");

    a_run_start_newest: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == fir31_pkg::ST_RUN && tap_reg == '0
                   && idx_reg == $past(wp_reg))
        else $error("tap walk does not start at newest sample");

endmodule

FILE: hw/rtl/fir_filter_31_tap_top.sv
// Top level of the 31-tap FIR low-pass filter.
`timescale 1ns / 1ps

// Each accepted sample is written into a circular delay line (zero at reset)
// and one filtered result follows. The block takes the sample, then does
// one tap per cycle through the single shared multiply-accumulate unit,
// which reads one delay-line word per cycle from the RAM, waits for the
// multiply and accumulate stages to empty, and then rounds and saturates
// the sum into the output register. The next sample is accepted as soon
// as the block is idle, even while the previous result still waits on
// out_ready; if that result is still not taken when the next one is ready,
// the block holds in its last step.
module fir_filter_31_tap_top #(
    parameter int TAPS        = 31,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fir31_pkg::OUT_BITS-1:0] filtered
);

    localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    fir31_pkg::mac_ctl_t    ctl;
    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [PTR_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    fir31_ctrl #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ctl       (ctl)
    );

    fir31_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fir31_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_data   (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the 31-tap FIR filter: driver, monitor and bit-true predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_TAPS     = 31;
    localparam int SAMPLE_W     = 14;
    localparam int SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SAMPLE_W - 1));
    localparam int OUT_MAX      = (1 << (fir31_pkg::OUT_BITS - 1)) - 1;
    localparam int OUT_MIN      = -(1 << (fir31_pkg::OUT_BITS - 1));
    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_WAIT     = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [fir31_pkg::OUT_BITS-1:0] filtered_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [3:0]          gap;
    } pending_sample_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    sample_t   sample    = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    filtered_t filtered;

    fir_filter_31_tap_top #(
        .TAPS        (NUM_TAPS),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

    // Predictor state: circular sample history (zero at reset) and its write slot
    sample_t         history [NUM_TAPS] = '{default: '0};
    int unsigned     write_slot = 0;
    filtered_t       filtered_due [$];
    pending_sample_t sample_backlog [$];

    int          errors          = 0;
    int unsigned samples_queued  = 0;
    int unsigned samples_taken   = 0;
    int unsigned idle_cycles     = 0;
    int unsigned results_taken   = 0;
    logic        in_taken        = 1'b0;
    logic        out_taken       = 1'b0;
    logic        ready_seen      = 1'b0;
    logic        valid_seen      = 1'b0;
    bit          staged          = 1'b0;
    sample_t     staged_value    = '0;
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;
    bit          quiet_output    = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int tap_weight(input int k);
        int m;
        m = (k > NUM_TAPS / 2) ? NUM_TAPS - 1 - k : k;
        case (m)
            0:       return -24;
            1:       return -12;
            2:       return 8;
            3:       return 50;
            4:       return 129;
            5:       return 256;
            6:       return 439;
            7:       return 682;
            8:       return 976;
            9:       return 1309;
            10:      return 1659;
            11:      return 1999;
            12:      return 2302;
            13:      return 2541;
            14:      return 2694;
            15:      return 2747;
            default: return 0;
        endcase
    endfunction

    // Store the sample, convolve newest first, round half up and clamp
    function automatic filtered_t predict_filtered(input sample_t s);
        longint acc;
        longint rounded;
        int     slot;
        history[write_slot] = s;
        acc = 0;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            slot = (write_slot + NUM_TAPS - k) % NUM_TAPS;
            acc += longint'(tap_weight(k)) * longint'(history[slot]);
        end
        write_slot = (write_slot + 1) % NUM_TAPS;
        rounded = (acc + (longint'(1) << (fir31_pkg::FRAC_SHIFT - 1)))
                  >>> fir31_pkg::FRAC_SHIFT;
        if (rounded > OUT_MAX)
            rounded = OUT_MAX;
        if (rounded < OUT_MIN)
            rounded = OUT_MIN;
        return filtered_t'(rounded);
    endfunction

    task automatic add_sample(input int value, input bit quiet);
        pending_sample_t item;
        item.value = sample_t'(value);
        item.gap   = quiet ? 4'd0 : 4'($urandom_range(0, MAX_WAIT));
        sample_backlog.push_back(item);
        samples_queued++;
    endtask

    // Sample both channels, check results and predict accepted samples
    always @(posedge clk or negedge rst_n)
    begin : check_transactions
        filtered_t oldest;
        if (!rst_n)
        begin
            in_taken    <= 1'b0;
            out_taken   <= 1'b0;
            ready_seen  <= 1'b0;
            valid_seen  <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_taken   <= in_valid && in_ready;
            out_taken  <= out_valid && out_ready;
            ready_seen <= in_ready;
            valid_seen <= out_valid;
            if (out_valid && out_ready)
            begin
                if (filtered_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, filtered);
                end
                else
                begin
                    oldest = filtered_due.pop_front();
                    if (filtered !== oldest)
                    begin
                        errors++;
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, oldest, filtered);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                filtered_due.push_back(predict_filtered(sample));
                samples_taken <= samples_taken + 1;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Gaps count only cycles in which the block was ready, so idling lands
    // only while the block waits for input
    always @(negedge clk)
    begin : drive_samples
        pending_sample_t next_item;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (!staged && sample_backlog.size() > 0)
            begin
                next_item    = sample_backlog.pop_front();
                staged_value = sample_t'(next_item.value);
                gap_left     = next_item.gap;
                staged       = 1'b1;
            end
            else if (staged && ready_seen && gap_left > 0)
                gap_left--;
            if (staged && gap_left == 0)
            begin
                sample   <= staged_value;
                in_valid <= 1'b1;
                staged    = 1'b0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall each result for a drawn number of cycles while it is offered (none in quiet stretches)
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                results_taken++;
                if (results_taken % 50 == 0)
                    quiet_output = ($urandom_range(0, 3) == 0);
                stall_left = quiet_output ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (valid_seen && stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    initial
    begin : run_test
        int  kind;
        int  len;
        int  value;
        bit  quiet;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Exact negative half at tap 5 with empty history: -64 * 256 = -2^14
        add_sample(-64, 1'b0);
        repeat (5) add_sample(0, 1'b0);
        // Impulse of full scale, then the extremes and bit patterns
        add_sample(SAMPLE_MAX, 1'b0);
        repeat (4) add_sample(0, 1'b0);
        add_sample(SAMPLE_MIN, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(1, 1'b0);
        add_sample(16'sh1555, 1'b1);
        add_sample(-16'sh1556, 1'b1);
        repeat (3) add_sample(SAMPLE_MAX, 1'b1);
        repeat (3) add_sample(SAMPLE_MIN, 1'b1);

        while (samples_queued < RANDOM_ITEMS + 24)
        begin
            kind  = $urandom_range(0, 9);
            len   = $urandom_range(20, 80);
            quiet = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    6:       value = SAMPLE_MAX;
                    7:       value = SAMPLE_MIN;
                    8:       value = int'($urandom_range(0, 8)) - 4;
                    9:       value = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
                    default: value = int'(sample_t'($urandom_range(0, (1 << SAMPLE_W) - 1)));
                endcase
                add_sample(value, quiet);
            end
        end

        while (samples_taken < samples_queued)
            @(negedge clk);
        while (filtered_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
